[rtl/pis_pkg.sv]
// Package for the priority insert stack: sizes, entry and result types,
// command codes and controller states. No dependencies.
`timescale 1ns / 1ps

package pis_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int PRIO_WIDTH  = 16;
    localparam int ADDR_WIDTH  = $clog2(DEPTH);
    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
    localparam int ENTRY_WIDTH = DATA_WIDTH + PRIO_WIDTH;

    typedef enum logic [1:0] {
        CMD_PUSH      = 2'd0,
        CMD_PUSH_PRIO = 2'd1,
        CMD_POP       = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SINK,
        ST_TAIL,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic signed [PRIO_WIDTH-1:0] prio;
        logic [DATA_WIDTH-1:0]        data;
    } entry_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]  pop_data;
        logic                   pop_valid;
        logic                   overflow;
        logic [COUNT_WIDTH-1:0] entry_count;
    } result_t;

endpackage

[rtl/pis_if.sv]
// Request and response channel interfaces of the priority insert stack.
// Depends on pis_pkg for field widths.
`timescale 1ns / 1ps

interface pis_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            cmd;
    logic [pis_pkg::DATA_WIDTH-1:0]        data;
    logic signed [pis_pkg::PRIO_WIDTH-1:0] priority_req;

    modport source (output valid, cmd, data, priority_req, input ready);
    modport sink   (input valid, cmd, data, priority_req, output ready);
endinterface

interface pis_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [pis_pkg::DATA_WIDTH-1:0]  pop_data;
    logic                            pop_valid;
    logic                            overflow;
    logic [pis_pkg::COUNT_WIDTH-1:0] entry_count;

    modport source (output valid, pop_data, pop_valid, overflow, entry_count, input ready);
    modport sink   (input valid, pop_data, pop_valid, overflow, entry_count, output ready);
endinterface

[rtl/pis_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/priority_insert_stack.sv]
// Top level of the priority insert stack: controller, fill count, output register.
// Depends on pis_pkg, pis_req_if, pis_rsp_if and pis_ram.
//
//   channel  role   word
//   req      sink   cmd, data, priority_req
//   rsp      source pop_data, pop_valid, overflow, entry_count
//
// Plain push, priority push onto an empty stack, overflow, empty pop, unused cmd: finish in IDLE.
// Pop: reads the entry RAM in IDLE, finishes in POP. Priority push onto n > 0 held entries: IDLE, SINK, TAIL,
// one compare-swap step per cycle through the single read and write port of the entry RAM.
// Reset clears the fill count, state, index and output valid; the entry RAM needs no clearing.
// A word is taken while a response waits; its own response then parks until rsp drains.
`timescale 1ns / 1ps

module priority_insert_stack (
    input  logic      clk,
    input  logic      rst_n,
    pis_req_if.sink   req,
    pis_rsp_if.source rsp
);

    localparam int AW = pis_pkg::ADDR_WIDTH;
    localparam int CW = pis_pkg::COUNT_WIDTH;

    pis_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [AW-1:0]    idx_reg, idx_next;
    pis_pkg::entry_t  carry_reg, carry_next;
    pis_pkg::result_t hold_reg, out_res_reg, res_next;
    logic             out_valid_reg;

    logic             accept, slot_free, finish, load_out, full, empty;
    pis_pkg::cmd_t    cmd;
    pis_pkg::entry_t  new_entry, lower;
    logic [CW-1:0]    fill_dec, fill_inc;

    logic                               ram_we;
    logic [AW-1:0]                      ram_waddr, ram_raddr;
    logic [pis_pkg::ENTRY_WIDTH-1:0]    ram_wdata, ram_rdata;

    pis_ram #(
        .WIDTH (pis_pkg::ENTRY_WIDTH),
        .DEPTH (pis_pkg::DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == pis_pkg::ST_IDLE);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign cmd       = pis_pkg::cmd_t'(req.cmd);
    assign full      = (fill_reg == CW'(pis_pkg::DEPTH));
    assign empty     = (fill_reg == '0);
    assign fill_dec  = fill_reg - CW'(1);
    assign fill_inc  = fill_reg + CW'(1);
    assign lower     = pis_pkg::entry_t'(ram_rdata);

    always_comb
    begin
        new_entry.data = req.data;
        new_entry.prio = (cmd == pis_pkg::CMD_PUSH_PRIO) ? req.priority_req : '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pis_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd == pis_pkg::CMD_POP && !empty)
                        state_next = pis_pkg::ST_POP;
                    else if (cmd == pis_pkg::CMD_PUSH_PRIO && !full && !empty)
                        state_next = pis_pkg::ST_SINK;
                    else
                        state_next = slot_free ? pis_pkg::ST_IDLE : pis_pkg::ST_HOLD;
                end
            end
            pis_pkg::ST_POP, pis_pkg::ST_TAIL, pis_pkg::ST_HOLD:
            begin
                state_next = slot_free ? pis_pkg::ST_IDLE : pis_pkg::ST_HOLD;
            end
            pis_pkg::ST_SINK:
            begin
                state_next = (idx_reg == AW'(1)) ? pis_pkg::ST_TAIL : pis_pkg::ST_SINK;
            end
            default:
            begin
                state_next = pis_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = carry_reg;
        ram_raddr  = idx_reg - AW'(2);
        finish     = 1'b0;
        res_next   = '0;
        fill_next  = fill_reg;
        carry_next = carry_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            pis_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        pis_pkg::CMD_PUSH, pis_pkg::CMD_PUSH_PRIO:
                        begin
                            if (full)
                            begin
                                finish               = 1'b1;
                                res_next.overflow    = 1'b1;
                                res_next.entry_count = fill_reg;
                            end
                            else
                            begin
                                fill_next = fill_inc;
                                if (cmd == pis_pkg::CMD_PUSH || empty)
                                begin
                                    ram_we               = 1'b1;
                                    ram_waddr            = fill_reg[AW-1:0];
                                    ram_wdata            = new_entry;
                                    finish               = 1'b1;
                                    res_next.entry_count = fill_inc;
                                end
                                else
                                begin
                                    carry_next = new_entry;
                                    idx_next   = fill_reg[AW-1:0];
                                    ram_raddr  = fill_dec[AW-1:0];
                                end
                            end
                        end
                        pis_pkg::CMD_POP:
                        begin
                            if (empty)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                fill_next = fill_dec;
                                ram_raddr = fill_dec[AW-1:0];
                            end
                        end
                        pis_pkg::CMD_NOP:
                        begin
                            finish               = 1'b1;
                            res_next.entry_count = fill_reg;
                        end
                        default:
                        begin
                            finish = 1'b0;
                        end
                    endcase
                end
            end
            pis_pkg::ST_POP:
            begin
                finish               = 1'b1;
                res_next.pop_data    = lower.data;
                res_next.pop_valid   = 1'b1;
                res_next.entry_count = fill_reg;
            end
            pis_pkg::ST_SINK:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg - AW'(1);
                if (carry_reg.prio > lower.prio)
                begin
                    ram_wdata = lower;
                end
                else
                begin
                    ram_wdata  = carry_reg;
                    carry_next = lower;
                end
            end
            pis_pkg::ST_TAIL:
            begin
                ram_we               = 1'b1;
                ram_waddr            = '0;
                finish               = 1'b1;
                res_next.entry_count = fill_reg;
            end
            pis_pkg::ST_HOLD:
            begin
                finish = 1'b0;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
        load_out = slot_free && (finish || state_reg == pis_pkg::ST_HOLD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pis_pkg::ST_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (finish && !slot_free)
        begin
            hold_reg <= res_next;
        end
        if (load_out)
        begin
            out_res_reg <= (state_reg == pis_pkg::ST_HOLD) ? hold_reg : res_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pop_data    = out_res_reg.pop_data;
    assign rsp.pop_valid   = out_res_reg.pop_valid;
    assign rsp.overflow    = out_res_reg.overflow;
    assign rsp.entry_count = out_res_reg.entry_count;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(pis_pkg::DEPTH))
        else $error("fill count above depth");

    a_sink_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pis_pkg::ST_SINK |-> idx_reg != '0)
        else $error("sink step at bottom entry");

    a_sink_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pis_pkg::ST_SINK && idx_reg != AW'(1) |-> ram_waddr != ram_raddr)
        else $error("sink read and write hit the same entry");

    a_hold_parked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pis_pkg::ST_HOLD |-> out_valid_reg)
        else $error("response parked while output register empty");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == pis_pkg::CMD_POP && !empty |=> fill_reg == $past(fill_dec))
        else $error("pop did not decrement fill count");

endmodule

[tb/sv/pis_checker.sv]
// Scoreboard for the priority insert stack: watches the req and rsp channels,
// keeps its own copy of the stack and compares every response word.
// Depends on pis_pkg, pis_req_if and pis_rsp_if.
`timescale 1ns / 1ps

module pis_checker (
    input  logic        clk,
    input  logic        rst_n,
    pis_req_if          req,
    pis_rsp_if          rsp,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    logic [pis_pkg::DATA_WIDTH-1:0]        stack_data [pis_pkg::DEPTH];
    logic signed [pis_pkg::PRIO_WIDTH-1:0] stack_prio [pis_pkg::DEPTH];
    int unsigned                           stack_fill;
    pis_pkg::result_t                      awaited_rsp [$];

    function automatic pis_pkg::result_t stack_update(
        input pis_pkg::cmd_t                         op,
        input logic [pis_pkg::DATA_WIDTH-1:0]        word_data,
        input logic signed [pis_pkg::PRIO_WIDTH-1:0] word_prio
    );
        pis_pkg::result_t                      res;
        int                                    i;
        logic [pis_pkg::DATA_WIDTH-1:0]        tmp_data;
        logic signed [pis_pkg::PRIO_WIDTH-1:0] tmp_prio;
        res = '0;
        case (op)
            pis_pkg::CMD_PUSH, pis_pkg::CMD_PUSH_PRIO:
            begin
                if (stack_fill >= pis_pkg::DEPTH)
                begin
                    res.overflow = 1'b1;
                end
                else
                begin
                    stack_data[stack_fill] = word_data;
                    stack_prio[stack_fill] = (op == pis_pkg::CMD_PUSH_PRIO) ? word_prio : '0;
                    stack_fill++;
                    if (op == pis_pkg::CMD_PUSH_PRIO)
                    begin
                        // one sink pass, top to bottom
                        for (i = int'(stack_fill) - 1; i > 0; i--)
                        begin
                            if (stack_prio[i] > stack_prio[i-1])
                            begin
                                tmp_data        = stack_data[i];
                                tmp_prio        = stack_prio[i];
                                stack_data[i]   = stack_data[i-1];
                                stack_prio[i]   = stack_prio[i-1];
                                stack_data[i-1] = tmp_data;
                                stack_prio[i-1] = tmp_prio;
                            end
                        end
                    end
                end
            end
            pis_pkg::CMD_POP:
            begin
                if (stack_fill > 0)
                begin
                    stack_fill--;
                    res.pop_data  = stack_data[stack_fill];
                    res.pop_valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = pis_pkg::COUNT_WIDTH'(stack_fill);
        return res;
    endfunction

    always @(posedge clk)
    begin
        pis_pkg::result_t want;
        if (!rst_n)
        begin
            stack_fill = 0;
            awaited_rsp.delete();
            fail_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t: rsp word expected none actual %h %b %b %0d",
                             $time, rsp.pop_data, rsp.pop_valid, rsp.overflow,
                             rsp.entry_count);
                    fail_count++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.pop_data !== want.pop_data)
                    begin
                        $display("%0t: pop_data expected %h actual %h",
                                 $time, want.pop_data, rsp.pop_data);
                        fail_count++;
                    end
                    if (rsp.pop_valid !== want.pop_valid)
                    begin
                        $display("%0t: pop_valid expected %b actual %b",
                                 $time, want.pop_valid, rsp.pop_valid);
                        fail_count++;
                    end
                    if (rsp.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.overflow, rsp.overflow);
                        fail_count++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, rsp.entry_count);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                awaited_rsp.push_back(stack_update(pis_pkg::cmd_t'(req.cmd), req.data,
                                                   req.priority_req));
            end
        end
        outstanding = awaited_rsp.size();
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the priority insert stack: clock, reset, request stimulus,
// response back-pressure and verdict. Depends on pis_pkg, the channel
// interfaces, priority_insert_stack and pis_checker.
`timescale 1ns / 1ps

module tb_top;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;

    pis_req_if req ();
    pis_rsp_if rsp ();

    priority_insert_stack dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    pis_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        #3_000_000;
        $display("** priority_insert_stack: FAILED **");
        $finish;
    end

    task automatic send_word(input pis_pkg::cmd_t op,
                             input logic [pis_pkg::DATA_WIDTH-1:0] word_data,
                             input logic [pis_pkg::PRIO_WIDTH-1:0] word_prio);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.cmd          <= op;
        req.data         <= word_data;
        req.priority_req <= word_prio;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned                    i;
        int unsigned                    pick;
        logic                           fill_bias;
        pis_pkg::cmd_t                  op;
        logic [pis_pkg::PRIO_WIDTH-1:0] prio;

        req.valid        = 1'b0;
        req.cmd          = pis_pkg::CMD_NOP;
        req.data         = '0;
        req.priority_req = '0;
        src_idle_pct     = 34;
        snk_idle_pct     = 48;
        fill_bias        = 1'b1;
        rst_n            = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pop, unused command, extremes, ties, full stack
        send_word(pis_pkg::CMD_POP, 32'hdeadbeef, 16'h0000);
        send_word(pis_pkg::CMD_NOP, 32'hffffffff, 16'h8000);
        send_word(pis_pkg::CMD_PUSH_PRIO, 32'hffffffff, 16'h7fff);
        send_word(pis_pkg::CMD_PUSH_PRIO, 32'h00000000, 16'h8000);
        send_word(pis_pkg::CMD_PUSH, 32'ha5a5a5a5, 16'h7fff);
        send_word(pis_pkg::CMD_PUSH_PRIO, 32'h00000001, 16'h0000);
        send_word(pis_pkg::CMD_PUSH_PRIO, 32'h00000002, 16'h8000);
        send_word(pis_pkg::CMD_PUSH_PRIO, 32'h00000003, 16'h7fff);
        for (i = 6; i < pis_pkg::DEPTH; i++)
        begin
            op = (i % 3 == 0) ? pis_pkg::CMD_PUSH : pis_pkg::CMD_PUSH_PRIO;
            send_word(op, $urandom, pis_pkg::PRIO_WIDTH'($urandom));
        end
        send_word(pis_pkg::CMD_PUSH, 32'h5555aaaa, 16'h0000);
        send_word(pis_pkg::CMD_PUSH_PRIO, 32'haaaa5555, 16'h8000);
        send_word(pis_pkg::CMD_POP, 32'h0, 16'h0);
        send_word(pis_pkg::CMD_POP, 32'hffffffff, 16'hffff);
        send_word(pis_pkg::CMD_POP, 32'h0, 16'h0);
        send_word(pis_pkg::CMD_NOP, 32'h12345678, 16'h1234);

        for (i = 0; i < 500; i++)
        begin
            if (i == 170)
            begin
                src_idle_pct = 48;
                snk_idle_pct = 34;
            end
            else if (i == 340)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (i % 40 == 0)
                fill_bias = ~fill_bias;
            pick = $urandom_range(99);
            if (pick < 5)
                op = pis_pkg::CMD_NOP;
            else if (pick < (fill_bias ? 72 : 35))
                op = ($urandom_range(3) == 0) ? pis_pkg::CMD_PUSH : pis_pkg::CMD_PUSH_PRIO;
            else
                op = pis_pkg::CMD_POP;
            case ($urandom_range(3))
                0:       prio = pis_pkg::PRIO_WIDTH'($urandom_range(6))
                                - pis_pkg::PRIO_WIDTH'(3);
                1:       prio = $urandom_range(1) ? 16'h8000 : 16'h7fff;
                default: prio = pis_pkg::PRIO_WIDTH'($urandom);
            endcase
            send_word(op, $urandom, prio);
        end
        req.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("** priority_insert_stack: PASSED **");
        else
            $display("** priority_insert_stack: FAILED **");
        $finish;
    end

endmodule
